// ===== rtl/sts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and codes for the sorted key table search block.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_KEY_WIDTH   = 32;

   localparam int ENTRY_COUNT_W = 9;
   localparam int ENTRY_INDEX_W = 8;
   localparam int KEY_VALUE_W   = 32;
   localparam int POSITION_W    = 9;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 9;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED_KEYS = 4'd1;

   // request modes
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [KEY_VALUE_W-1:0]   key_value;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [POSITION_W-1:0] position;
   } rsp_type;

   typedef struct packed {
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic                     signed_keys;
   } cfg_type;

endpackage

// ===== rtl/sts_key_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_key_mem
// Key table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sts_key_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] key_mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sts_search_eng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_search_eng
// Request sequencer: table writes and lower-bound binary search, one probe
// per cycle against the key memory.
// ----------------------------------------------------------------------------
module sts_search_eng #(
   parameter int TABLE_DEPTH = 256,
   parameter int KEY_WIDTH   = 32,
   parameter int IDX_W       = 8,
   parameter int CNT_W       = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sts_pkg::req_type     req_word,
   input  sts_pkg::cfg_type     cfg,
   input  logic                 res_ready,
   output logic                 res_valid,
   output sts_pkg::rsp_type     res_word,
   output logic                 mem_we,
   output logic [IDX_W-1:0]     mem_waddr,
   output logic [KEY_WIDTH-1:0] mem_wdata,
   output logic                 mem_re,
   output logic [IDX_W-1:0]     mem_raddr,
   input  logic [KEY_WIDTH-1:0] mem_rdata
);
   import sts_pkg::*;

   localparam int CMP_W = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PROBE = 3'b010,
      ST_FINAL = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [KEY_WIDTH-1:0] target_ff, target_in;
   logic                 inrange_ff, inrange_in;

   logic [KEY_WIDTH-1:0] flip;
   logic [KEY_WIDTH-1:0] probe_key;
   logic [CNT_W-1:0]     count_c;
   logic [CNT_W-1:0]     half;
   logic [CNT_W-1:0]     probe;
   logic                 less;
   logic [CNT_W-1:0]     lo_n;
   logic [CNT_W-1:0]     len_n;
   logic                 lo_n_in_range;

   // order mapping: flip the sign bit so an unsigned compare works for both
   assign flip      = {cfg.signed_keys, {(KEY_WIDTH-1){1'b0}}};
   assign probe_key = mem_rdata ^ flip;

   assign count_c = (CMP_W'(cfg.entry_count) > CMP_W'(TABLE_DEPTH))
                    ? CNT_W'(TABLE_DEPTH) : CNT_W'(cfg.entry_count);

   // both outcomes of the probe are prepared; the compare only selects
   assign half  = len_ff >> 1;
   assign probe = lo_ff + half;
   assign less  = probe_key < target_ff;
   assign lo_n  = less ? (probe + CNT_W'(1)) : lo_ff;
   assign len_n = less ? (len_ff - half - CNT_W'(1)) : half;
   assign lo_n_in_range = lo_n < count_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign mem_waddr = IDX_W'(req_word.entry_index);
   assign mem_wdata = KEY_WIDTH'(req_word.key_value);

   always_comb begin
      state_in   = state_ff;
      lo_in      = lo_ff;
      len_in     = len_ff;
      count_in   = count_ff;
      target_in  = target_ff;
      inrange_in = inrange_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_raddr  = IDX_W'(lo_n + (len_n >> 1));
      res_valid  = 1'b0;
      res_word.found    = inrange_ff && ((mem_rdata ^ flip) == target_ff);
      res_word.position = POSITION_W'(lo_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_word.mode == MODE_WRITE) begin
                  mem_we = 32'(req_word.entry_index) < 32'(TABLE_DEPTH);
               end else begin
                  target_in = KEY_WIDTH'(req_word.key_value) ^ flip;
                  lo_in     = '0;
                  len_in    = count_c;
                  count_in  = count_c;
                  if (count_c == '0) begin
                     inrange_in = 1'b0;
                     state_in   = ST_FINAL;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = IDX_W'(count_c >> 1);
                     state_in  = ST_PROBE;
                  end
               end
            end
         end
         ST_PROBE: begin
            lo_in  = lo_n;
            len_in = len_n;
            if (len_n == '0) begin
               // last step: fetch the entry at the bound for the match test
               mem_re     = lo_n_in_range;
               mem_raddr  = IDX_W'(lo_n);
               inrange_in = lo_n_in_range;
               state_in   = ST_FINAL;
            end else begin
               mem_re = 1'b1;
            end
         end
         ST_FINAL: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      len_ff     <= len_in;
      count_ff   <= count_in;
      target_ff  <= target_in;
      inrange_ff <= inrange_in;
   end

endmodule

// ===== rtl/sorted_table_insert_position_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_position_search_top
// Sorted key table with lower-bound search (found flag and insert position).
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid / req_stall / req_word): a write word stores
//    key_value at entry_index and gives no response; a search word gives one
//    rsp word with found and position (match index or insert position).
//  - csr channel: csr_index 0 = entry_count, 1 = signed_keys; csr_ready is
//    always high. Write registers only while no search is in flight.
//  - A write word does not raise req_stall. A search runs P probes, at most
//    floor(log2(count)) + 1 for a nonzero count (9 at 256 entries) and none
//    for an empty table. The single key memory read port allows one probe
//    per cycle, then one read of the final bound for the equality check
//    when that bound is below the count.
//  - req_stall is high while a search runs; the next word is taken once the
//    result has moved to the rsp register, even if rsp_stall is high.
//  - rsp_stall holds the rsp register; a second finished search waits in
//    the engine until the register drains.
//  - Reset clears the registers and control; table contents are undefined
//    until written.
// ----------------------------------------------------------------------------
module sorted_table_insert_position_search_top #(
   parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_WIDTH   = sts_pkg::DEF_KEY_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sts_pkg::req_type                 req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sts_pkg::rsp_type                 rsp_word,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sts_pkg::CSR_DATA_W-1:0]   csr_data
);
   import sts_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // configuration registers
   logic [ENTRY_COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic                     signed_keys_ff, signed_keys_in;
   cfg_type                  cfg;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_word_ff, rsp_word_in;
   logic    rsp_space;

   // engine / memory
   logic                 eng_valid;
   rsp_type              eng_word;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [KEY_WIDTH-1:0] mem_wdata;
   logic                 mem_re;
   logic [IDX_W-1:0]     mem_raddr;
   logic [KEY_WIDTH-1:0] mem_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      entry_count_in = entry_count_ff;
      signed_keys_in = signed_keys_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT: entry_count_in = csr_data[ENTRY_COUNT_W-1:0];
            CSR_SIGNED_KEYS: signed_keys_in = csr_data[0];
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         signed_keys_ff <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         signed_keys_ff <= signed_keys_in;
      end
   end

   assign cfg.entry_count = entry_count_ff;
   assign cfg.signed_keys = signed_keys_ff;

   sts_key_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (KEY_WIDTH),
      .AW    (IDX_W)
   ) u_key_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   sts_search_eng #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_search_eng (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cfg       (cfg),
      .res_ready (rsp_space),
      .res_valid (eng_valid),
      .res_word  (eng_word),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // rsp register: loads when empty or draining this cycle
   assign rsp_space    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = (eng_valid && rsp_space) || (rsp_valid_ff && rsp_stall);
   assign rsp_word_in  = (eng_valid && rsp_space) ? eng_word : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef NO_ASSERTIONS
   // table writes only come from an accepted write word
   a_mem_we_from_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (req_valid && !req_stall && req_word.mode == MODE_WRITE))
      else $error("key memory written outside an accepted write word");

   // a write word never yields a response
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_word.mode == MODE_WRITE) |=> !eng_valid)
      else $error("response produced for a write word");

   // search bound never passes the configured count
   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      eng_valid |-> (eng_word.position <= entry_count_ff))
      else $error("search position beyond entry count");

   // a finished search holds in the engine until the rsp register has room
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (eng_valid && !rsp_space) |=> (eng_valid && $stable(eng_word)))
      else $error("search result lost while rsp register full");
`endif

endmodule
